### rtl/core/rsu_pkg.sv
// ----------------------------------------------------------------------------
// rsu_pkg
// Shared types and constants of the clock snapshot to Unix time converter.
// ----------------------------------------------------------------------------
`default_nettype none

package rsu_pkg;

    localparam int unsigned YEAR_W = 12;
    localparam int unsigned CENT_W = 5;

    // classified request handed from the front end to the back end
    typedef struct packed {
        logic              valid;
        logic [YEAR_W-1:0] year;
        logic [CENT_W-1:0] cent_q;
        logic              leap;
        logic [3:0]        month;
        logic [4:0]        day;
        logic [4:0]        hour;
        logic [5:0]        minute;
        logic [5:0]        second;
    } rsu_item_t;

endpackage

`default_nettype wire

### rtl/core/rsu_front.sv
// ----------------------------------------------------------------------------
// rsu_front
// Decodes and range-checks one raw register snapshot and builds the request
// for the back end: full year, leap flag, century term and time of day.
// ----------------------------------------------------------------------------
`default_nettype none

module rsu_front (
    input  wire logic [7:0]         raw_status_b,
    input  wire logic [7:0]         raw_second,
    input  wire logic [7:0]         raw_minute,
    input  wire logic [7:0]         raw_hour,
    input  wire logic [7:0]         raw_day,
    input  wire logic [7:0]         raw_month,
    input  wire logic [7:0]         raw_year,
    input  wire logic [7:0]         raw_century,
    output rsu_pkg::rsu_item_t      item
);
    import rsu_pkg::*;

    localparam logic [YEAR_W-1:0] YEAR_FIRST = 12'd1970;
    localparam logic [YEAR_W-1:0] YEAR_LAST  = 12'd2999;
    localparam logic [7:0]        CENT_MIN   = 8'd19;
    localparam logic [7:0]        CENT_MAX   = 8'd29;
    localparam logic [7:0]        PIVOT      = 8'd70;
    localparam logic [7:0]        NIBBLE_MAX = 8'd9;
    localparam logic [7:0]        BCD_MASK   = 8'h0F;
    localparam logic [7:0]        HOUR_PM    = 8'h80;

    function automatic logic digits_ok(input logic [7:0] v, input logic bin);
        logic [7:0] lo;
        logic [7:0] hi;
        lo = v & BCD_MASK;
        hi = v >> 4;
        return bin || (lo <= NIBBLE_MAX && hi <= NIBBLE_MAX);
    endfunction

    function automatic logic [7:0] dec_val(input logic [7:0] v, input logic bin);
        logic [7:0] lo;
        logic [7:0] hi;
        lo = v & BCD_MASK;
        hi = v >> 4;
        return bin ? v : 8'(hi * 8'd10 + lo);
    endfunction

    function automatic logic [4:0] days_in_month(input logic [7:0] m, input logic leap);
        logic [4:0] len;
        unique case (m)
            8'd2:                      len = leap ? 5'd29 : 5'd28;
            8'd4, 8'd6, 8'd9, 8'd11:   len = 5'd30;
            default:                   len = 5'd31;
        endcase
        return len;
    endfunction

    logic                bin;
    logic                h24;
    logic                pm;
    logic [7:0]          hour_byte;
    logic [7:0]          sec_v;
    logic [7:0]          min_v;
    logic [7:0]          hr_v;
    logic [7:0]          day_v;
    logic [7:0]          mon_v;
    logic [7:0]          yr_v;
    logic [7:0]          cent_v;
    logic                bytes_ok;
    logic                hr12_ok;
    logic [7:0]          hr12;
    logic [7:0]          hr24;
    logic                cent_trust;
    logic [CENT_W-1:0]   cent;
    logic [YEAR_W-1:0]   year;
    logic                leap;
    logic                date_ok;

    assign bin       = raw_status_b[2];
    assign h24       = raw_status_b[1];
    assign pm        = !h24 && raw_hour[7];
    assign hour_byte = h24 ? raw_hour : (raw_hour & ~HOUR_PM);

    assign sec_v  = dec_val(raw_second, bin);
    assign min_v  = dec_val(raw_minute, bin);
    assign hr_v   = dec_val(hour_byte, bin);
    assign day_v  = dec_val(raw_day, bin);
    assign mon_v  = dec_val(raw_month, bin);
    assign yr_v   = dec_val(raw_year, bin);
    assign cent_v = dec_val(raw_century, bin);

    assign bytes_ok = digits_ok(raw_second, bin) && digits_ok(raw_minute, bin)
                   && digits_ok(hour_byte, bin) && digits_ok(raw_day, bin)
                   && digits_ok(raw_month, bin) && digits_ok(raw_year, bin)
                   && yr_v <= 8'd99;

    // twelve-hour form: 12 am is 0, 12 pm is 12
    assign hr12_ok = h24 || (hr_v >= 8'd1 && hr_v <= 8'd12);
    assign hr12    = (hr_v == 8'd12) ? 8'd0 : hr_v;
    assign hr24    = h24 ? hr_v : (hr12 + (pm ? 8'd12 : 8'd0));

    assign cent_trust = digits_ok(raw_century, bin) && cent_v >= CENT_MIN && cent_v <= CENT_MAX;
    assign cent       = cent_trust ? cent_v[CENT_W-1:0]
                      : ((yr_v < PIVOT) ? CENT_W'(20) : CENT_W'(19));
    assign year       = YEAR_W'(cent) * YEAR_W'(100) + YEAR_W'(yr_v[6:0]);

    // 100 is a multiple of four, so the two-digit part alone settles year mod 4
    assign leap = (yr_v[6:0] != 7'd0) ? (yr_v[1:0] == 2'd0) : (cent[1:0] == 2'd0);

    assign date_ok = year >= YEAR_FIRST && year <= YEAR_LAST
                  && mon_v >= 8'd1 && mon_v <= 8'd12
                  && hr24 <= 8'd23 && min_v <= 8'd59 && sec_v <= 8'd59
                  && day_v >= 8'd1 && day_v <= {3'b000, days_in_month(mon_v, leap)};

    always_comb
    begin
        item.valid  = bytes_ok && hr12_ok && date_ok;
        item.year   = year;
        // centuries below the year, for the leap day count up to the previous year
        item.cent_q = (yr_v[6:0] == 7'd0) ? cent - CENT_W'(1) : cent;
        item.leap   = leap;
        item.month  = mon_v[3:0];
        item.day    = day_v[4:0];
        item.hour   = hr24[4:0];
        item.minute = min_v[5:0];
        item.second = sec_v[5:0];
    end

endmodule

`default_nettype wire

### rtl/core/rsu_queue.sv
// ----------------------------------------------------------------------------
// rsu_queue
// Short first-in first-out queue of classified requests between the front
// end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module rsu_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    input  wire rsu_pkg::rsu_item_t  push_item,
    input  wire logic                pop,
    output rsu_pkg::rsu_item_t       head_item,
    output logic                     empty,
    output logic                     full
);
    import rsu_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    rsu_item_t        mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign empty     = (count_reg == CNT_W'(0));
    assign full      = (count_reg == CNT_W'(DEPTH));
    assign head_item = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? PTR_W'(0) : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? PTR_W'(0) : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow : assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full && !pop))
        else $error("request pushed into full queue");
    a_no_underflow : assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && empty))
        else $error("request popped from empty queue");
    a_count_drop : assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !push) |=> count_reg == $past(count_reg) - CNT_W'(1))
        else $error("queue count did not fall on pop");
`endif

endmodule

`default_nettype wire

### rtl/core/rsu_back.sv
// ----------------------------------------------------------------------------
// rsu_back
// Two-stage converter: day count since the epoch and time of day, then
// Unix seconds and weekday with invalid readings forced to zero.
// ----------------------------------------------------------------------------
`default_nettype none

module rsu_back (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                take,
    input  wire rsu_pkg::rsu_item_t  item,
    output logic                     done,
    output logic                     status,
    output logic [11:0]              out_year,
    output logic [3:0]               out_month,
    output logic [4:0]               out_day,
    output logic [4:0]               out_hour,
    output logic [5:0]               out_minute,
    output logic [5:0]               out_second,
    output logic [34:0]              unix_seconds,
    output logic [2:0]               weekday
);
    import rsu_pkg::*;

    localparam int unsigned DAYS_W = 19;
    localparam int unsigned WIDE_W = 21;
    localparam int unsigned TOD_W  = 17;
    localparam int unsigned TS_W   = 35;
    localparam logic [WIDE_W-1:0] DAY_EPOCH   = 21'd719162;
    localparam logic [WIDE_W-1:0] DAYS_YEAR   = 21'd365;
    localparam logic [TOD_W-1:0]  SEC_HOUR    = 17'd3600;
    localparam logic [TOD_W-1:0]  SEC_MIN     = 17'd60;
    localparam logic [TOD_W-1:0]  SEC_DAY     = 17'd86400;
    localparam logic [DAYS_W-1:0] EPOCH_WDAY  = 19'd4;

    function automatic logic [8:0] days_before_month(input logic [3:0] m);
        logic [8:0] s;
        unique case (m)
            4'd2:    s = 9'd31;
            4'd3:    s = 9'd59;
            4'd4:    s = 9'd90;
            4'd5:    s = 9'd120;
            4'd6:    s = 9'd151;
            4'd7:    s = 9'd181;
            4'd8:    s = 9'd212;
            4'd9:    s = 9'd243;
            4'd10:   s = 9'd273;
            4'd11:   s = 9'd304;
            4'd12:   s = 9'd334;
            default: s = 9'd0;
        endcase
        return s;
    endfunction

    // eight is one mod seven, so octal digits are summed and folded
    function automatic logic [2:0] mod7(input logic [DAYS_W-1:0] v);
        logic [5:0] s1;
        logic [3:0] s2;
        logic [2:0] s3;
        s1 = 6'(v[2:0]) + 6'(v[5:3]) + 6'(v[8:6]) + 6'(v[11:9])
           + 6'(v[14:12]) + 6'(v[17:15]) + 6'(v[18]);
        s2 = 4'(s1[5:3]) + 4'(s1[2:0]);
        s3 = 3'(s2[3]) + s2[2:0];
        return (s3 == 3'd7) ? 3'd0 : s3;
    endfunction

    logic [YEAR_W-1:0] prev_year;
    logic [WIDE_W-1:0] year_days;
    logic [WIDE_W-1:0] all_days;
    logic [TOD_W-1:0]  tod;

    logic              v1_reg;
    logic              ok1_reg;
    logic [DAYS_W-1:0] days_reg;
    logic [TOD_W-1:0]  tod_reg;
    logic [YEAR_W-1:0] year1_reg;
    logic [3:0]        month1_reg;
    logic [4:0]        day1_reg;
    logic [4:0]        hour1_reg;
    logic [5:0]        minute1_reg;
    logic [5:0]        second1_reg;

    logic [TS_W:0]     ts_next;
    logic [2:0]        wday_next;

    logic              done_reg;
    logic              status_reg;
    logic [11:0]       year2_reg;
    logic [3:0]        month_reg;
    logic [4:0]        day_reg;
    logic [4:0]        hour_reg;
    logic [5:0]        minute_reg;
    logic [5:0]        second_reg;
    logic [TS_W-1:0]   ts_reg;
    logic [2:0]        wday_reg;

    assign prev_year = item.year - YEAR_W'(1);
    assign year_days = WIDE_W'(prev_year) * DAYS_YEAR + WIDE_W'(prev_year >> 2)
                     - WIDE_W'(item.cent_q) + WIDE_W'(item.cent_q >> 2) - DAY_EPOCH;
    assign all_days  = year_days + WIDE_W'(days_before_month(item.month)) + WIDE_W'(item.day)
                     - WIDE_W'(1) + WIDE_W'(item.leap && item.month > 4'd2);
    assign tod       = TOD_W'(item.hour) * SEC_HOUR + TOD_W'(item.minute) * SEC_MIN
                     + TOD_W'(item.second);

    assign ts_next   = (TS_W+1)'(days_reg) * (TS_W+1)'(SEC_DAY) + (TS_W+1)'(tod_reg);
    assign wday_next = mod7(days_reg + EPOCH_WDAY);

    always_ff @(posedge clk)
    begin
        days_reg    <= all_days[DAYS_W-1:0];
        tod_reg     <= tod;
        year1_reg   <= item.year;
        month1_reg  <= item.month;
        day1_reg    <= item.day;
        hour1_reg   <= item.hour;
        minute1_reg <= item.minute;
        second1_reg <= item.second;
        ok1_reg     <= item.valid;
        status_reg  <= !ok1_reg;
        year2_reg   <= ok1_reg ? year1_reg : '0;
        month_reg   <= ok1_reg ? month1_reg : '0;
        day_reg     <= ok1_reg ? day1_reg : '0;
        hour_reg    <= ok1_reg ? hour1_reg : '0;
        minute_reg  <= ok1_reg ? minute1_reg : '0;
        second_reg  <= ok1_reg ? second1_reg : '0;
        ts_reg      <= ok1_reg ? ts_next[TS_W-1:0] : '0;
        wday_reg    <= ok1_reg ? wday_next : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= take;
            done_reg <= v1_reg;
        end
    end

    assign done         = done_reg;
    assign status       = status_reg;
    assign out_year     = year2_reg;
    assign out_month    = month_reg;
    assign out_day      = day_reg;
    assign out_hour     = hour_reg;
    assign out_minute   = minute_reg;
    assign out_second   = second_reg;
    assign unix_seconds = ts_reg;
    assign weekday      = wday_reg;

`ifndef SYNTHESIS
    a_latency : assert property (@(posedge clk) disable iff (!rst_n)
        take |=> ##1 done_reg)
        else $error("result strobe not two cycles after request");
    a_invalid_zero : assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && status_reg) |-> (year2_reg == '0 && month_reg == '0
            && ts_reg == '0 && wday_reg == '0 && day_reg == '0))
        else $error("invalid reading with non-zero fields");
    a_valid_range : assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && !status_reg) |-> (month_reg >= 4'd1 && month_reg <= 4'd12
            && wday_reg <= 3'd6 && day_reg >= 5'd1))
        else $error("valid reading with out-of-range fields");
`endif

endmodule

`default_nettype wire

### rtl/core/rtc_snapshot_to_unix_time.sv
// ----------------------------------------------------------------------------
// rtc_snapshot_to_unix_time
// Converts a raw clock chip register snapshot into calendar fields, Unix
// seconds and weekday, flagging invalid readings.
//
//   channel   handshake        payload
//   request   start / busy     raw_status_b .. raw_century
//   result    done (strobe)    status, out_year .. weekday
//
// one request per cycle while busy is low; the result strobe rises after its request
// passes the decode and queue write, then the day count, then the seconds multiply
// the result strobe lasts one cycle and the receiver cannot stall it
// busy rises only when the request queue is full
// reset empties the queue and the pipeline, no clearing pass is needed
// ----------------------------------------------------------------------------
`default_nettype none

module rtc_snapshot_to_unix_time #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [7:0]  raw_status_b,
    input  wire logic [7:0]  raw_second,
    input  wire logic [7:0]  raw_minute,
    input  wire logic [7:0]  raw_hour,
    input  wire logic [7:0]  raw_day,
    input  wire logic [7:0]  raw_month,
    input  wire logic [7:0]  raw_year,
    input  wire logic [7:0]  raw_century,
    output logic             done,
    output logic             status,
    output logic [11:0]      out_year,
    output logic [3:0]       out_month,
    output logic [4:0]       out_day,
    output logic [4:0]       out_hour,
    output logic [5:0]       out_minute,
    output logic [5:0]       out_second,
    output logic [34:0]      unix_seconds,
    output logic [2:0]       weekday
);
    import rsu_pkg::*;

    rsu_item_t front_item;
    rsu_item_t head_item;
    logic      push;
    logic      pop;
    logic      q_empty;
    logic      q_full;

    assign busy = q_full;
    assign push = start && !q_full;
    assign pop  = !q_empty;

    rsu_front u_front (
        .raw_status_b (raw_status_b),
        .raw_second   (raw_second),
        .raw_minute   (raw_minute),
        .raw_hour     (raw_hour),
        .raw_day      (raw_day),
        .raw_month    (raw_month),
        .raw_year     (raw_year),
        .raw_century  (raw_century),
        .item         (front_item)
    );

    rsu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (front_item),
        .pop       (pop),
        .head_item (head_item),
        .empty     (q_empty),
        .full      (q_full)
    );

    rsu_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .take         (pop),
        .item         (head_item),
        .done         (done),
        .status       (status),
        .out_year     (out_year),
        .out_month    (out_month),
        .out_day      (out_day),
        .out_hour     (out_hour),
        .out_minute   (out_minute),
        .out_second   (out_second),
        .unix_seconds (unix_seconds),
        .weekday      (weekday)
    );

endmodule

`default_nettype wire

### test/tb_rtc_snapshot_to_unix_time.sv
// ----------------------------------------------------------------------------
// tb_rtc_snapshot_to_unix_time
// Self-checking bench for the clock snapshot to Unix time converter. Directed
// snapshots cover the calendar corners, hour coding and decode faults; random
// snapshots, mostly well-formed dates with some corrupted or pure noise, follow
// with random gaps between requests. Every result is checked field by field
// against an in-bench calendar model held by a small scoreboard.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_rtc_snapshot_to_unix_time;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned YEAR_FIRST    = 1970;
    localparam int unsigned YEAR_LAST     = 2999;
    localparam int unsigned SB_BINARY_BIT = 2;
    localparam int unsigned SB_H24_BIT    = 1;
    localparam logic [7:0]  HOUR_PM       = 8'h80;
    localparam logic [7:0]  SB_BCD_12     = 8'h00;
    localparam logic [7:0]  SB_BCD_24     = 8'h02;
    localparam logic [7:0]  SB_BIN_12     = 8'h04;
    localparam logic [7:0]  SB_BIN_24     = 8'h06;
    localparam logic        READING_OK    = 1'b0;
    localparam logic        READING_BAD   = 1'b1;
    localparam int unsigned NUM_RANDOM    = 1280;
    localparam int unsigned STALL_LIMIT   = 1000;
    localparam int unsigned SETTLE_CYCLES = 8;

    localparam int unsigned DAYS_IN_MONTH [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
    localparam int unsigned MONTH_START   [12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273,
                                                   304, 334};

    typedef struct packed {
        logic [7:0] mode_byte;
        logic [7:0] second;
        logic [7:0] minute;
        logic [7:0] hour;
        logic [7:0] day;
        logic [7:0] month;
        logic [7:0] year;
        logic [7:0] century;
    } snapshot_t;

    typedef struct packed {
        logic                      status;
        logic [rsu_pkg::YEAR_W-1:0] year;
        logic [3:0]                month;
        logic [4:0]                day;
        logic [4:0]                hour;
        logic [5:0]                minute;
        logic [5:0]                second;
        logic [34:0]               unix_s;
        logic [2:0]                wday;
    } reading_t;

    class reading_board;
        reading_t expected_q[$];
        int       errors;
        int       checked;
        int       valid_seen;

        function new();
            errors     = 0;
            checked    = 0;
            valid_seen = 0;
        endfunction

        function int byte_value(logic [7:0] v, bit bin);
            if (bin)
                return int'(v);
            if (v[3:0] > 9 || v[7:4] > 9)
                return -1;
            return int'(v[7:4]) * 10 + int'(v[3:0]);
        endfunction

        function reading_t predict(snapshot_t s);
            reading_t    r;
            bit          bin;
            bit          h24;
            bit          pm;
            bit          leap;
            logic [7:0]  hraw;
            int          sec_v;
            int          min_v;
            int          hr_v;
            int          day_v;
            int          mon_v;
            int          yy_v;
            int          cent_v;
            int unsigned yfull;
            int unsigned mlen;
            longint      p;
            longint      days;
            longint      ts;
            r        = '0;
            r.status = READING_BAD;
            bin      = s.mode_byte[SB_BINARY_BIT];
            h24      = s.mode_byte[SB_H24_BIT];
            hraw     = s.hour;
            pm       = 1'b0;
            if (!h24)
            begin
                pm   = (hraw & HOUR_PM) != 0;
                hraw = hraw & ~HOUR_PM;
            end
            sec_v  = byte_value(s.second, bin);
            min_v  = byte_value(s.minute, bin);
            hr_v   = byte_value(hraw, bin);
            day_v  = byte_value(s.day, bin);
            mon_v  = byte_value(s.month, bin);
            yy_v   = byte_value(s.year, bin);
            cent_v = byte_value(s.century, bin);
            if (sec_v < 0 || min_v < 0 || hr_v < 0 || day_v < 0 || mon_v < 0 || yy_v < 0)
                return r;
            if (yy_v > 99)
                return r;
            if (!h24)
            begin
                if (hr_v < 1 || hr_v > 12)
                    return r;
                hr_v = hr_v % 12;
                if (pm)
                    hr_v += 12;
            end
            if (cent_v >= 19 && cent_v <= 29)
                yfull = cent_v * 100 + yy_v;
            else if (yy_v < 70)
                yfull = 2000 + yy_v;
            else
                yfull = 1900 + yy_v;
            if (yfull < YEAR_FIRST || yfull > YEAR_LAST)
                return r;
            if (mon_v < 1 || mon_v > 12)
                return r;
            if (hr_v > 23 || min_v > 59 || sec_v > 59)
                return r;
            leap = ((yfull % 4) == 0 && (yfull % 100) != 0) || (yfull % 400) == 0;
            mlen = DAYS_IN_MONTH[mon_v-1];
            if (mon_v == 2 && leap)
                mlen = 29;
            if (day_v < 1 || day_v > mlen)
                return r;
            p    = longint'(yfull) - 1;
            days = p * 365 + p / 4 - p / 100 + p / 400 - 719162
                   + MONTH_START[mon_v-1] + day_v - 1;
            if (mon_v > 2 && leap)
                days += 1;
            ts = days * 86400 + hr_v * 3600 + min_v * 60 + sec_v;
            r.status = READING_OK;
            r.year   = yfull[rsu_pkg::YEAR_W-1:0];
            r.month  = mon_v[3:0];
            r.day    = day_v[4:0];
            r.hour   = hr_v[4:0];
            r.minute = min_v[5:0];
            r.second = sec_v[5:0];
            r.unix_s = ts[34:0];
            r.wday   = 3'((days + 4) % 7);
            return r;
        endfunction

        function void note_request(snapshot_t s);
            expected_q.push_back(predict(s));
        endfunction

        function void compare(string field, logic [34:0] want, logic [34:0] got);
            if (got !== want)
            begin
                $error("%s mismatch: expected %0d, got %0d", field, want, got);
                errors++;
            end
        endfunction

        function void check_result(reading_t got);
            reading_t want;
            if (expected_q.size() == 0)
            begin
                $error("result strobe with no request outstanding");
                errors++;
                return;
            end
            want = expected_q.pop_front();
            checked++;
            if (want.status == READING_OK)
                valid_seen++;
            compare("status", want.status, got.status);
            compare("out_year", want.year, got.year);
            compare("out_month", want.month, got.month);
            compare("out_day", want.day, got.day);
            compare("out_hour", want.hour, got.hour);
            compare("out_minute", want.minute, got.minute);
            compare("out_second", want.second, got.second);
            compare("unix_seconds", want.unix_s, got.unix_s);
            compare("weekday", want.wday, got.wday);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    snapshot_t   req;
    logic        done;
    logic        status;
    logic [11:0] out_year;
    logic [3:0]  out_month;
    logic [4:0]  out_day;
    logic [4:0]  out_hour;
    logic [5:0]  out_minute;
    logic [5:0]  out_second;
    logic [34:0] unix_seconds;
    logic [2:0]  weekday;

    reading_board board = new();
    int           sent;

    rtc_snapshot_to_unix_time dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .raw_status_b (req.mode_byte),
        .raw_second   (req.second),
        .raw_minute   (req.minute),
        .raw_hour     (req.hour),
        .raw_day      (req.day),
        .raw_month    (req.month),
        .raw_year     (req.year),
        .raw_century  (req.century),
        .done         (done),
        .status       (status),
        .out_year     (out_year),
        .out_month    (out_month),
        .out_day      (out_day),
        .out_hour     (out_hour),
        .out_minute   (out_minute),
        .out_second   (out_second),
        .unix_seconds (unix_seconds),
        .weekday      (weekday)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n && start && !busy)
            board.note_request(req);
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
            board.check_result({status, out_year, out_month, out_day, out_hour,
                                out_minute, out_second, unix_seconds, weekday});
    end

    // cycles with neither a request taken nor a result seen
    initial
    begin
        int unsigned idle;
        idle = 0;
        while (idle < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((rst_n && start && !busy) || (rst_n && done))
                idle = 0;
            else
                idle++;
        end
        $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
        $display("tb_rtc_snapshot_to_unix_time: done, errors");
        $finish;
    end

    function automatic logic [7:0] encode_field(int unsigned v, bit bin);
        if (bin)
            return 8'(v);
        return 8'(((v / 10) << 4) | (v % 10));
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // entered and left just after a falling edge
    task automatic send_snapshot(snapshot_t s, int unsigned gap);
        bit taken;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req   <= s;
        start <= 1'b1;
        taken = 1'b0;
        while (!taken)
        begin
            @(posedge clk);
            taken = !busy;
            @(negedge clk);
        end
        sent++;
    endtask

    task automatic make_random_snapshot(output snapshot_t s);
        int unsigned pick;
        int unsigned cent;
        int unsigned yy;
        int unsigned yfull;
        int unsigned mon;
        int unsigned dlen;
        int unsigned day_v;
        int unsigned hr_v;
        int unsigned min_v;
        int unsigned sec_v;
        int unsigned h12;
        bit          bin;
        bit          h24;
        bit          leap;
        pick      = $urandom_range(0, 99);
        s.mode_byte = 8'($urandom);
        s.second   = 8'($urandom);
        s.minute   = 8'($urandom);
        s.hour     = 8'($urandom);
        s.day      = 8'($urandom);
        s.month    = 8'($urandom);
        s.year     = 8'($urandom);
        s.century  = 8'($urandom);
        // pure noise
        if (pick < 10)
            return;
        bin = $urandom_range(0, 1);
        h24 = $urandom_range(0, 1);
        s.mode_byte[SB_BINARY_BIT] = bin;
        s.mode_byte[SB_H24_BIT]    = h24;
        yy = $urandom_range(0, 99);
        if ($urandom_range(0, 1))
        begin
            cent      = $urandom_range(19, 29);
            yfull     = cent * 100 + yy;
            s.century = encode_field(cent, bin);
        end
        else
        begin
            yfull = (yy < 70) ? 2000 + yy : 1900 + yy;
            if ($urandom_range(0, 3) == 0)
                s.century = 8'($urandom_range(160, 255));
            else
            begin
                cent = $urandom_range(0, 88);
                if (cent >= 19)
                    cent += 11;
                s.century = encode_field(cent, bin);
            end
        end
        leap  = ((yfull % 4) == 0 && (yfull % 100) != 0) || (yfull % 400) == 0;
        mon   = $urandom_range(1, 12);
        dlen  = DAYS_IN_MONTH[mon-1] + ((mon == 2 && leap) ? 1 : 0);
        day_v = ($urandom_range(0, 3) == 0) ? dlen : $urandom_range(1, dlen);
        hr_v  = ($urandom_range(0, 7) == 0) ? 23 : $urandom_range(0, 23);
        min_v = ($urandom_range(0, 7) == 0) ? 59 : $urandom_range(0, 59);
        sec_v = ($urandom_range(0, 7) == 0) ? 59 : $urandom_range(0, 59);
        s.year   = encode_field(yy, bin);
        s.month  = encode_field(mon, bin);
        s.day    = encode_field(day_v, bin);
        s.minute = encode_field(min_v, bin);
        s.second = encode_field(sec_v, bin);
        if (h24)
            s.hour = encode_field(hr_v, bin);
        else
        begin
            h12 = hr_v % 12;
            if (h12 == 0)
                h12 = 12;
            s.hour = encode_field(h12, bin) | ((hr_v >= 12) ? HOUR_PM : 8'h00);
        end
        // broken snapshot: one register byte overwritten
        if (pick >= 85)
        begin
            case ($urandom_range(0, 7))
                0: s.mode_byte = 8'($urandom);
                1: s.second   = 8'($urandom);
                2: s.minute   = 8'($urandom);
                3: s.hour     = 8'($urandom);
                4: s.day      = 8'($urandom);
                5: s.month    = 8'($urandom);
                6: s.year     = 8'($urandom);
                default: s.century = 8'($urandom);
            endcase
        end
    endtask

    initial
    begin
        snapshot_t   directed_q[$];
        snapshot_t   s;
        int unsigned burst;
        rst_n = 1'b0;
        start = 1'b0;
        req   = '0;
        sent  = 0;
        burst = 0;

        // epoch, all-zero and all-ones bytes, last second of the range
        directed_q.push_back('{SB_BCD_24, 8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h70, 8'h00});
        directed_q.push_back('{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00});
        directed_q.push_back('{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF});
        directed_q.push_back('{SB_BCD_24, 8'h59, 8'h59, 8'h23, 8'h31, 8'h12, 8'h99, 8'h29});
        // leap day rules
        directed_q.push_back('{SB_BIN_24, 8'd0, 8'd0, 8'd0, 8'd29, 8'd2, 8'd0, 8'd20});
        directed_q.push_back('{SB_BCD_24, 8'h00, 8'h00, 8'h00, 8'h29, 8'h02, 8'h00, 8'h21});
        directed_q.push_back('{SB_BCD_24, 8'h00, 8'h00, 8'h00, 8'h29, 8'h02, 8'h00, 8'h24});
        // twelve-hour coding
        directed_q.push_back('{SB_BCD_12, 8'h30, 8'h15, 8'h12, 8'h15, 8'h06, 8'h24, 8'h20});
        directed_q.push_back('{SB_BCD_12, 8'h30, 8'h15, 8'h92, 8'h15, 8'h06, 8'h24, 8'h20});
        directed_q.push_back('{SB_BIN_12, 8'd59, 8'd59, 8'h8B, 8'd31, 8'd12, 8'd69, 8'd0});
        directed_q.push_back('{SB_BCD_12, 8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h24, 8'h20});
        directed_q.push_back('{SB_BCD_12, 8'h00, 8'h00, 8'h13, 8'h01, 8'h01, 8'h24, 8'h20});
        // bad bcd digits, untrusted century falls back to the pivot
        directed_q.push_back('{SB_BCD_24, 8'h5A, 8'h00, 8'h00, 8'h01, 8'h01, 8'h24, 8'h20});
        directed_q.push_back('{SB_BCD_24, 8'h00, 8'hA0, 8'h00, 8'h01, 8'h01, 8'h24, 8'h20});
        directed_q.push_back('{SB_BCD_24, 8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h69, 8'h2A});
        // year byte above ninety-nine, pivot and century edges
        directed_q.push_back('{SB_BIN_24, 8'd0, 8'd0, 8'd0, 8'd1, 8'd1, 8'd100, 8'd20});
        directed_q.push_back('{SB_BCD_24, 8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h99, 8'h18});
        directed_q.push_back('{SB_BCD_24, 8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h69, 8'h19});
        // calendar ranges
        directed_q.push_back('{SB_BCD_24, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h24, 8'h20});
        directed_q.push_back('{SB_BCD_24, 8'h00, 8'h00, 8'h00, 8'h01, 8'h13, 8'h24, 8'h20});
        directed_q.push_back('{SB_BCD_24, 8'h00, 8'h00, 8'h00, 8'h31, 8'h04, 8'h24, 8'h20});
        directed_q.push_back('{SB_BCD_24, 8'h00, 8'h60, 8'h00, 8'h01, 8'h01, 8'h24, 8'h20});
        directed_q.push_back('{SB_BCD_24, 8'h60, 8'h00, 8'h00, 8'h01, 8'h01, 8'h24, 8'h20});
        directed_q.push_back('{SB_BCD_24, 8'h00, 8'h00, 8'h24, 8'h01, 8'h01, 8'h24, 8'h20});
        // spare status b bits set
        directed_q.push_back('{8'hFE, 8'd59, 8'd59, 8'd23, 8'd28, 8'd2, 8'd99, 8'd29});

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_q[i])
            send_snapshot(directed_q[i], pick_gap());

        repeat (NUM_RANDOM)
        begin
            make_random_snapshot(s);
            if (burst == 0 && $urandom_range(0, 49) == 0)
                burst = $urandom_range(10, 40);
            if (burst > 0)
            begin
                burst--;
                send_snapshot(s, 0);
            end
            else
                send_snapshot(s, pick_gap());
        end
        start <= 1'b0;

        while (board.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (board.pending() != 0)
        begin
            $error("%0d results never arrived", board.pending());
            board.errors++;
        end

        $display("%0d snapshots sent, %0d results checked (%0d valid, %0d rejected)",
                 sent, board.checked, board.valid_seen, board.checked - board.valid_seen);
        if (board.errors == 0)
            $display("tb_rtc_snapshot_to_unix_time: done, clean");
        else
            $display("tb_rtc_snapshot_to_unix_time: done, errors");
        $finish;
    end

endmodule

`default_nettype wire

### sim.f
rtl/core/rsu_pkg.sv
rtl/core/rsu_front.sv
rtl/core/rsu_queue.sv
rtl/core/rsu_back.sv
rtl/core/rtc_snapshot_to_unix_time.sv
test/tb_rtc_snapshot_to_unix_time.sv
